// File: hdl/rapp_pkg.sv
// Shared widths, register indexes and reset values for the point rotate-and-project core.
package rapp_pkg;

    // Field widths
    localparam int COORD_W   = 16;   // signed Q8.8 world coordinate
    localparam int TRIG_W    = 16;   // signed Q1.14 sine or cosine
    localparam int SCALE_W   = 16;   // unsigned Q8.8 pixel scale
    localparam int PIX_W     = 8;    // screen coordinate
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Screen size defaults
    localparam int SCREEN_WIDTH_DEF  = 240;
    localparam int SCREEN_HEIGHT_DEF = 240;

    // Register reset values
    localparam logic signed [TRIG_W-1:0] TRIG_ONE   = 16'sd16384;
    localparam logic signed [TRIG_W-1:0] TRIG_ZERO  = 16'sd0;
    localparam logic [SCALE_W-1:0]       SCALE_ONE  = 16'd256;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS_YAW     = 3'd0,
        CFG_SIN_YAW     = 3'd1,
        CFG_COS_TILT    = 3'd2,
        CFG_SIN_TILT    = 3'd3,
        CFG_COS_ROLL    = 3'd4,
        CFG_SIN_ROLL    = 3'd5,
        CFG_PIXEL_SCALE = 3'd6
    } t_cfg_idx;

endpackage

// File: hdl/rotate_and_project_point_core.sv
// Top level: yaw/tilt/roll rotation and orthographic projection of one point per cycle.
//
// Rotates a signed Q8.8 point by yaw, tilt and roll (Q1.14 sines and cosines from the
// configuration registers), scales the rotated x and y by the Q8.8 pixel scale, rounds
// half away from zero and offsets to the screen centre with y pointing down. Points off
// the screen come out with visible low and zero coordinates. The core takes one point
// per cycle while it is not stalled and returns its result through 11 registered stages;
// the depth is set by the chain of multiplier stages (yaw, tilt/roll, split roll
// products, split scale products) and the 80-bit rounding add. Every stage holds
// its request while the next one holds, and empty stages keep accepting, so a stall
// on the output only backs up the input once all 11 stages are occupied. Arithmetic is
// exact at full width, with no saturation. Configuration writes are always accepted and
// must only be issued while no point is in flight.
module rotate_and_project_point_core #(
    parameter int SCREEN_WIDTH  = rapp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = rapp_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Point requests
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [rapp_pkg::COORD_W-1:0]   i_point_x,
    input  logic signed [rapp_pkg::COORD_W-1:0]   i_point_y,
    input  logic signed [rapp_pkg::COORD_W-1:0]   i_point_z,
    // Result requests
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [rapp_pkg::PIX_W-1:0]            o_screen_x,
    output logic [rapp_pkg::PIX_W-1:0]            o_screen_y,
    output logic                                  o_visible,
    // Configuration writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [rapp_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [rapp_pkg::CFG_DAT_W-1:0]        i_cfg_data
);
    import rapp_pkg::*;

    localparam int NS = 11;          // pipeline stages, output register included
    localparam int CW = 24;          // signed screen coordinate before range check
    localparam logic signed [CW-1:0] HALF_W = CW'(SCREEN_WIDTH / 2);
    localparam logic signed [CW-1:0] HALF_H = CW'(SCREEN_HEIGHT / 2);
    localparam logic signed [CW-1:0] LIM_W  = CW'(SCREEN_WIDTH);
    localparam logic signed [CW-1:0] LIM_H  = CW'(SCREEN_HEIGHT);
    localparam logic [79:0]          RND    = 80'(1) << 57;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [TRIG_W-1:0] r_cos_yaw, r_sin_yaw, r_cos_tilt, r_sin_tilt;
    logic signed [TRIG_W-1:0] r_cos_roll, r_sin_roll;
    logic [SCALE_W-1:0]       r_scale;

    assign o_cfg_ready = 1'b1;

    // Store a configuration write, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_yaw  <= TRIG_ONE;
            r_sin_yaw  <= TRIG_ZERO;
            r_cos_tilt <= TRIG_ONE;
            r_sin_tilt <= TRIG_ZERO;
            r_cos_roll <= TRIG_ONE;
            r_sin_roll <= TRIG_ZERO;
            r_scale    <= SCALE_ONE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_COS_YAW:     r_cos_yaw  <= $signed(i_cfg_data);
                CFG_SIN_YAW:     r_sin_yaw  <= $signed(i_cfg_data);
                CFG_COS_TILT:    r_cos_tilt <= $signed(i_cfg_data);
                CFG_SIN_TILT:    r_sin_tilt <= $signed(i_cfg_data);
                CFG_COS_ROLL:    r_cos_roll <= $signed(i_cfg_data);
                CFG_SIN_ROLL:    r_sin_roll <= $signed(i_cfg_data);
                CFG_PIXEL_SCALE: r_scale    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valids and per-stage advance
    // ------------------------------------------------------------------
    logic [NS-1:0] r_vld, n_vld, w_en;

    // Advance a stage when it is empty or its successor advances
    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int s = NS - 2; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (w_en[0]) begin
            n_vld[0] = i_valid;
        end
        for (int s = 1; s < NS; s++) begin
            if (w_en[s]) begin
                n_vld[s] = r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[NS-1];

    // ------------------------------------------------------------------
    // Stage 1: yaw products and y * cos_tilt
    // ------------------------------------------------------------------
    logic signed [31:0] r1_xc, r1_xs, r1_zc, r1_zs, r1_yct;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_xc  <= 32'(i_point_x) * 32'(r_cos_yaw);
            r1_xs  <= 32'(i_point_x) * 32'(r_sin_yaw);
            r1_zc  <= 32'(i_point_z) * 32'(r_cos_yaw);
            r1_zs  <= 32'(i_point_z) * 32'(r_sin_yaw);
            r1_yct <= 32'(i_point_y) * 32'(r_cos_tilt);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: yaw sums, scale 2^22
    // ------------------------------------------------------------------
    logic signed [32:0] r2_rx1, r2_rz1;
    logic signed [31:0] r2_yct;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_rx1 <= 33'(r1_xc) + 33'(r1_zs);
            r2_rz1 <= 33'(r1_zc) - 33'(r1_xs);
            r2_yct <= r1_yct;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: tilt product and roll products of rx1
    // ------------------------------------------------------------------
    logic signed [48:0] r3_rzst, r3_rxcr, r3_rxsr;
    logic signed [31:0] r3_yct;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_rzst <= 49'(r2_rz1) * 49'(r_sin_tilt);
            r3_rxcr <= 49'(r2_rx1) * 49'(r_cos_roll);
            r3_rxsr <= 49'(r2_rx1) * 49'(r_sin_roll);
            r3_yct  <= r2_yct;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: tilted y, scale 2^36
    // ------------------------------------------------------------------
    logic signed [48:0] r4_ry2, r4_rxcr, r4_rxsr;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_ry2  <= (49'(r3_yct) <<< 14) - r3_rzst;
            r4_rxcr <= r3_rxcr;
            r4_rxsr <= r3_rxsr;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: roll products of ry2, split into high and low halves
    // ------------------------------------------------------------------
    logic signed [24:0] w_ry2_hi, w_ry2_lo;
    logic signed [40:0] r5_hs, r5_ls, r5_hc, r5_lc;
    logic signed [48:0] r5_rxcr, r5_rxsr;

    assign w_ry2_hi = $signed(r4_ry2[48:24]);
    assign w_ry2_lo = $signed({1'b0, r4_ry2[23:0]});

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r5_hs   <= 41'(w_ry2_hi) * 41'(r_sin_roll);
            r5_ls   <= 41'(w_ry2_lo) * 41'(r_sin_roll);
            r5_hc   <= 41'(w_ry2_hi) * 41'(r_cos_roll);
            r5_lc   <= 41'(w_ry2_lo) * 41'(r_cos_roll);
            r5_rxcr <= r4_rxcr;
            r5_rxsr <= r4_rxsr;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: recombine the split roll products
    // ------------------------------------------------------------------
    logic signed [63:0] r6_ry2s, r6_ry2c;
    logic signed [48:0] r6_rxcr, r6_rxsr;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r6_ry2s <= (64'(r5_hs) <<< 24) + 64'(r5_ls);
            r6_ry2c <= (64'(r5_hc) <<< 24) + 64'(r5_lc);
            r6_rxcr <= r5_rxcr;
            r6_rxsr <= r5_rxsr;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: rolled x and y, scale 2^50
    // ------------------------------------------------------------------
    logic signed [63:0] r7_rx3, r7_ry3;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r7_rx3 <= (64'(r6_rxcr) <<< 14) - r6_ry2s;
            r7_ry3 <= (64'(r6_rxsr) <<< 14) + r6_ry2c;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: sign and magnitude
    // ------------------------------------------------------------------
    logic signed [63:0] w_rx3_neg, w_ry3_neg;
    logic [62:0]        r8_magx, r8_magy;
    logic               r8_negx, r8_negy;

    assign w_rx3_neg = -r7_rx3;
    assign w_ry3_neg = -r7_ry3;

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r8_negx <= r7_rx3[63];
            r8_negy <= r7_ry3[63];
            r8_magx <= r7_rx3[63] ? w_rx3_neg[62:0] : r7_rx3[62:0];
            r8_magy <= r7_ry3[63] ? w_ry3_neg[62:0] : r7_ry3[62:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: magnitude times pixel scale, as two partial products
    // ------------------------------------------------------------------
    logic [46:0] r9_ax, r9_ay;
    logic [47:0] r9_bx, r9_by;
    logic        r9_negx, r9_negy;

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r9_ax   <= 47'(r8_magx[62:32]) * 47'(r_scale);
            r9_ay   <= 47'(r8_magy[62:32]) * 47'(r_scale);
            r9_bx   <= 48'(r8_magx[31:0]) * 48'(r_scale);
            r9_by   <= 48'(r8_magy[31:0]) * 48'(r_scale);
            r9_negx <= r8_negx;
            r9_negy <= r8_negy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: sum partial products, round half up, drop 58 bits
    // ------------------------------------------------------------------
    logic [79:0] w_totx, w_toty;
    logic [21:0] r10_qx, r10_qy;
    logic        r10_negx, r10_negy;

    assign w_totx = 80'({r9_ax, 32'd0}) + 80'(r9_bx) + RND;
    assign w_toty = 80'({r9_ay, 32'd0}) + 80'(r9_by) + RND;

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            r10_qx   <= w_totx[79:58];
            r10_qy   <= w_toty[79:58];
            r10_negx <= r9_negx;
            r10_negy <= r9_negy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: restore sign, center on screen, range check
    // ------------------------------------------------------------------
    logic signed [CW-1:0] w_qx, w_qy, w_dx, w_dy, w_sx, w_sy;
    logic                 w_vis;
    logic [PIX_W-1:0]     r_sx, r_sy;
    logic                 r_vis;

    always_comb begin
        w_qx  = $signed(CW'(r10_qx));
        w_qy  = $signed(CW'(r10_qy));
        w_dx  = r10_negx ? -w_qx : w_qx;
        w_dy  = r10_negy ? -w_qy : w_qy;
        w_sx  = HALF_W + w_dx;
        w_sy  = HALF_H - w_dy;
        w_vis = (w_sx >= 0) && (w_sx < LIM_W) && (w_sy >= 0) && (w_sy < LIM_H);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[10]) begin
            r_sx  <= w_vis ? w_sx[PIX_W-1:0] : '0;
            r_sy  <= w_vis ? w_sy[PIX_W-1:0] : '0;
            r_vis <= w_vis;
        end
    end

    assign o_screen_x = r_sx;
    assign o_screen_y = r_sy;
    assign o_visible  = r_vis;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Off-screen results carry zero coordinates
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_visible) |-> (o_screen_x == '0 && o_screen_y == '0))
        else $error("hidden point with nonzero coordinates");

    // Input backs up only when every stage holds a request
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld && i_stall))
        else $error("input stalled with a free stage");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && r_vld == '0))
        else $error("pipeline not empty after reset");

    // A request held at the output keeps its result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_sx) && $stable(r_sy) && $stable(r_vis)))
        else $error("stalled result changed");

endmodule
